// File: rtl/http_content_length_extractor_core_defines.svh
// ----------------------------------------------------------------------------
// Content-length extractor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef HTTP_CONTENT_LENGTH_EXTRACTOR_CORE_DEFINES_SVH
`define HTTP_CONTENT_LENGTH_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define HCLX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCLX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hclx_pkg.sv
// ----------------------------------------------------------------------------
// hclx_pkg
// Types, codes and the header-name key for the content-length extractor.
// ----------------------------------------------------------------------------
package hclx_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 64;
  localparam int unsigned RESULT_BITS     = 64;
  localparam int unsigned KEY_LEN         = 14;

  // Message phase
  localparam logic [1:0] PH_FIRST   = 2'd0;
  localparam logic [1:0] PH_HEADERS = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  // Position within a header line
  localparam logic [1:0] VS_NAME   = 2'd0;
  localparam logic [1:0] VS_SKIP   = 2'd1;
  localparam logic [1:0] VS_DIGITS = 2'd2;
  localparam logic [1:0] VS_IGNORE = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } msg_t;

  typedef struct packed {
    logic                   header_complete;
    logic                   length_found;
    logic [RESULT_BITS-1:0] length_value;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       pending_cr;
    logic       line_is_empty;
    logic [3:0] name_position;
    logic       name_mismatch;
    logic [1:0] value_stage;
    logic       digit_seen;
    logic       overflowed;
    logic       have_length;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{
    phase:         PH_FIRST,
    pending_cr:    1'b0,
    line_is_empty: 1'b1,
    name_position: 4'd0,
    name_mismatch: 1'b0,
    value_stage:   VS_NAME,
    digit_seen:    1'b0,
    overflowed:    1'b0,
    have_length:   1'b0
  };

  // Lower-case "content-length", one letter per position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6f; // o
      4'd2:    ch = 8'h6e; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2d; // -
      4'd8:    ch = 8'h6c; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6e; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/hclx_step.sv
// ----------------------------------------------------------------------------
// hclx_step
// Next-state and result logic for one message byte.
// ----------------------------------------------------------------------------
module hclx_step import hclx_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  ctrl_t                  ctrl,
  input  logic [LENGTH_BITS-1:0] acc,
  input  logic [LENGTH_BITS-1:0] best,
  input  msg_t                   item,
  output ctrl_t                  ctrl_next,
  output logic [LENGTH_BITS-1:0] acc_next,
  output logic [LENGTH_BITS-1:0] best_next,
  output logic                   emit,
  output res_t                   result
);

  localparam int unsigned WIDE_BITS = LENGTH_BITS + 4;

  logic [7:0]           c;
  logic                 is_digit;
  logic [WIDE_BITS-1:0] wide;
  logic                 wrap;
  logic                 take;
  logic                 complete;
  ctrl_t                mid;

  // One text byte of a line; CR that did not start a line end lands here too
  function automatic ctrl_t content(input ctrl_t s, input logic [7:0] ch,
                                    input logic wrap_in);
    ctrl_t      r;
    logic [7:0] low;
    r   = s;
    low = (ch inside {[CH_UP_A:CH_UP_Z]}) ? ch + CASE_OFS : ch;
    r.line_is_empty = 1'b0;
    if (s.phase == PH_HEADERS) begin
      case (s.value_stage)
        VS_NAME: begin
          if (ch == CH_COLON) begin
            r.value_stage = (!s.name_mismatch && s.name_position == 4'(KEY_LEN))
                            ? VS_SKIP : VS_IGNORE;
          end else if (s.name_position < 4'(KEY_LEN) &&
                       low == key_char(s.name_position)) begin
            r.name_position = s.name_position + 4'd1;
          end else begin
            r.name_mismatch = 1'b1;
          end
        end
        VS_SKIP, VS_DIGITS: begin
          if (ch inside {[CH_ZERO:CH_NINE]}) begin
            r.value_stage = VS_DIGITS;
            r.digit_seen  = 1'b1;
            r.overflowed  = s.overflowed | wrap_in;
          end else if (!(s.value_stage == VS_SKIP && (ch == CH_SP || ch == CH_TAB))) begin
            r.value_stage = VS_IGNORE;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  function automatic ctrl_t clear_line(input ctrl_t s);
    ctrl_t r;
    r               = s;
    r.line_is_empty = 1'b1;
    r.name_position = 4'd0;
    r.name_mismatch = 1'b0;
    r.value_stage   = VS_NAME;
    r.digit_seen    = 1'b0;
    r.overflowed    = 1'b0;
    return r;
  endfunction

  assign c        = item.data_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  // acc * 10 + digit, with four spare bits to catch overflow
  assign wide = (WIDE_BITS'(acc) << 3) + (WIDE_BITS'(acc) << 1) +
                WIDE_BITS'(c - CH_ZERO);
  assign wrap = |wide[WIDE_BITS-1:LENGTH_BITS];

  always_comb begin
    ctrl_next = ctrl;
    acc_next  = acc;
    best_next = best;
    emit      = 1'b0;
    result    = '0;
    complete  = 1'b0;
    take      = 1'b0;
    mid       = ctrl;

    if (ctrl.phase == PH_DONE) begin
      // drop body bytes until the message ends
      if (item.last_byte) begin
        ctrl_next = CTRL_RESET;
        acc_next  = '0;
        best_next = '0;
      end
    end else begin
      if (c == CH_LF && ctrl.pending_cr) begin
        ctrl_next.pending_cr = 1'b0;
        if (ctrl.phase == PH_FIRST) begin
          ctrl_next       = clear_line(ctrl_next);
          ctrl_next.phase = PH_HEADERS;
          acc_next        = '0;
        end else if (ctrl.line_is_empty) begin
          ctrl_next.phase = PH_DONE;
          complete        = 1'b1;
        end else begin
          if (ctrl.digit_seen && !ctrl.overflowed) begin
            ctrl_next.have_length = 1'b1;
            best_next             = acc;
          end
          ctrl_next = clear_line(ctrl_next);
          acc_next  = '0;
        end
      end else begin
        mid.pending_cr = 1'b0;
        if (ctrl.pending_cr) begin
          mid = content(mid, CH_CR, 1'b0);
        end
        if (c == CH_CR) begin
          ctrl_next            = mid;
          ctrl_next.pending_cr = 1'b1;
        end else begin
          ctrl_next = content(mid, c, wrap);
          take = (mid.phase == PH_HEADERS) && is_digit &&
                 (mid.value_stage == VS_SKIP || mid.value_stage == VS_DIGITS);
          if (take && !mid.overflowed && !wrap) begin
            acc_next = wide[LENGTH_BITS-1:0];
          end
        end
      end

      if (complete) begin
        emit                   = 1'b1;
        result.header_complete = 1'b1;
        result.length_found    = ctrl_next.have_length;
        result.length_value    = ctrl_next.have_length ? RESULT_BITS'(best_next) : '0;
      end else if (item.last_byte) begin
        emit = 1'b1;
      end
      if (item.last_byte) begin
        ctrl_next = CTRL_RESET;
        acc_next  = '0;
        best_next = '0;
      end
    end
  end

endmodule

// File: rtl/http_content_length_extractor_core.sv
// A result is loaded into the output register in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while msg_stall is low; the parse state and the decimal accumulate
//   (one shift-add per digit) are combinational logic between registers.
// Input stalls only while a finished result waits on a stalled output.
// Reset (rst, synchronous): parser back to the first line, no length, output empty.
// ----------------------------------------------------------------------------
// http_content_length_extractor_core
// Scans an HTTP message byte by byte and reports the content-length value
// found in its header block, or not-found if it has none or the message ends early.
// ----------------------------------------------------------------------------
`include "http_content_length_extractor_core_defines.svh"

module http_content_length_extractor_core import hclx_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // message byte channel
  input  logic msg_valid,
  output logic msg_stall,
  input  msg_t msg,
  // result channel
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  // Parser state: control bits plus the running and the last good length
  ctrl_t                  ctrl;
  logic [LENGTH_BITS-1:0] acc;
  logic [LENGTH_BITS-1:0] best;

  ctrl_t                  ctrl_next;
  logic [LENGTH_BITS-1:0] acc_next;
  logic [LENGTH_BITS-1:0] best_next;
  logic                   emit;
  res_t                   step_res;
  logic                   accept;

  // Hold the input only while a result sits unclaimed in the output register;
  // a result taken this cycle frees the register for the next item.
  assign msg_stall = res_valid && res_stall;
  assign accept    = msg_valid && !msg_stall;

  hclx_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .ctrl      (ctrl),
    .acc       (acc),
    .best      (best),
    .item      (msg),
    .ctrl_next (ctrl_next),
    .acc_next  (acc_next),
    .best_next (best_next),
    .emit      (emit),
    .result    (step_res)
  );

  // Advance the parser on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= CTRL_RESET;
      acc  <= '0;
      best <= '0;
    end else if (accept) begin
      ctrl <= ctrl_next;
      acc  <= acc_next;
      best <= best_next;
    end
  end

  // Output register: load a new result, or drop the old one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res <= step_res;
    end
  end

  // A found length only comes with a complete header block
  `HCLX_ASSERT_IMP(a_found_implies_complete, res_valid && res.length_found,
    res.header_complete, "length_found without header_complete")
  // Not-found results carry a zero length
  `HCLX_ASSERT_IMP(a_zero_when_missing, res_valid && !res.length_found,
    res.length_value == '0, "nonzero length_value without length_found")
  // The blank line moves the parser into the body unless the message also ends
  `HCLX_ASSERT_NXT(a_done_after_blank,
    accept && emit && step_res.header_complete && !msg.last_byte,
    ctrl.phase == PH_DONE, "parser not in body phase after blank line")
  // Outside header lines the per-line state stays cleared
  `HCLX_ASSERT_IMP(a_line_clear, ctrl.phase != PH_HEADERS,
    ctrl.value_stage == VS_NAME && !ctrl.digit_seen, "line state active outside headers")

endmodule
